[rtl/labs_energy_min_search_defines.svh]
// Assertion macros used by the block's result queue.
`ifndef LABS_ENERGY_MIN_SEARCH_DEFINES_SVH
`define LABS_ENERGY_MIN_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LABS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define LABS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/labs_ems_pkg.sv]
`timescale 1ns / 1ps
package labs_ems_pkg;

  // Sequence length limits
  localparam int MAX_LEN   = 32;
  localparam int CAND_W    = 32;
  localparam int LEN_CAP   = (MAX_LEN < CAND_W) ? MAX_LEN : CAND_W;
  localparam int NUM_CELLS = LEN_CAP - 1;
  localparam int LAG_W     = (LEN_CAP > 2) ? $clog2(LEN_CAP) : 1;

  // Field widths
  localparam int LEN_W    = 6;
  localparam int ENERGY_W = 14;
  localparam int CORR_W   = LEN_W + 2;
  localparam int SQ_W     = 2 * LEN_W;
  localparam int CNT_W    = $clog2(CAND_W + 1);

  localparam logic [LEN_W-1:0]    LEN_RESET  = LEN_W'(32);
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

  // Result queue
  localparam int FIFO_DEPTH = 128;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [CAND_W-1:0] candidate;
    logic              restart;
  } item_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic [CAND_W-1:0]   best_candidate;
    logic [ENERGY_W-1:0] best_energy;
  } result_t;

  // Item as it travels down the cell chain
  typedef struct packed {
    logic [CAND_W-1:0]   candidate;
    logic                restart;
    logic [LEN_W-1:0]    len;
    logic [ENERGY_W-1:0] sum;
  } stage_t;

endpackage

[rtl/labs_ems_cell.sv]
`timescale 1ns / 1ps
module labs_ems_cell import labs_ems_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [LAG_W-1:0] lag,
  input  logic             in_valid,
  input  stage_t           in_stage,
  output logic             out_valid,
  output stage_t           out_stage
);

  // Population count, byte by byte
  function automatic logic [CNT_W-1:0] popcount(input logic [CAND_W-1:0] v);
    logic [CNT_W-1:0] total;
    logic [3:0]       part;
    total = '0;
    for (int b = 0; b < CAND_W / 8; b++) begin
      part = '0;
      for (int i = 0; i < 8; i++) begin
        part = part + 4'(v[8*b+i]);
      end
      total = total + CNT_W'(part);
    end
    return total;
  endfunction

  logic                     active;
  logic [LEN_W-1:0]         span;
  logic [CAND_W-1:0]        keep;
  logic [CAND_W-1:0]        differ;
  logic [CNT_W-1:0]         ones;
  logic signed [CORR_W-1:0] corr;

  logic                     mid_valid;
  stage_t                   mid_stage;
  logic signed [CORR_W-1:0] mid_corr;

  logic [CORR_W-1:0]        mag;
  logic [SQ_W-1:0]          sq;
  logic [ENERGY_W:0]        sum_wide;
  logic [ENERGY_W-1:0]      sum_next;
  stage_t                   stage_next;

  // C_k = span - 2 * (number of differing pairs)
  always_comb begin
    active = LEN_W'(lag) < in_stage.len;
    span   = in_stage.len - LEN_W'(lag);
    keep   = (CAND_W'(1) << span) - CAND_W'(1);
    differ = (in_stage.candidate ^ (in_stage.candidate >> lag)) & keep;
    ones   = popcount(differ);
    if (active) begin
      corr = $signed(CORR_W'(span)) - $signed(CORR_W'({ones, 1'b0}));
    end else begin
      corr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    mid_stage <= in_stage;
    mid_corr  <= corr;
  end

  // Square and accumulate, saturating as a guard
  always_comb begin
    mag            = mid_corr[CORR_W-1] ? CORR_W'(-mid_corr) : CORR_W'(mid_corr);
    sq             = mag[LEN_W-1:0] * mag[LEN_W-1:0];
    sum_wide       = (ENERGY_W+1)'(mid_stage.sum) + (ENERGY_W+1)'(sq);
    sum_next       = sum_wide[ENERGY_W] ? ENERGY_MAX : sum_wide[ENERGY_W-1:0];
    stage_next     = mid_stage;
    stage_next.sum = sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_stage <= stage_next;
  end

endmodule

[rtl/labs_ems_min.sv]
`timescale 1ns / 1ps
module labs_ems_min import labs_ems_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  stage_t  in_stage,
  output logic    wr_en,
  output result_t wr_data
);

  logic [ENERGY_W-1:0] min_energy;
  logic [CAND_W-1:0]   min_mask;

  logic [ENERGY_W-1:0] base_energy;
  logic [CAND_W-1:0]   base_mask;
  logic [ENERGY_W-1:0] min_energy_next;
  logic [CAND_W-1:0]   min_mask_next;

  // Restart clears the minimum; ties keep the earlier mask
  always_comb begin
    base_energy = in_stage.restart ? ENERGY_MAX : min_energy;
    base_mask   = in_stage.restart ? '0 : min_mask;
    if (in_stage.sum < base_energy) begin
      min_energy_next = in_stage.sum;
      min_mask_next   = in_stage.candidate;
    end else begin
      min_energy_next = base_energy;
      min_mask_next   = base_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_energy <= ENERGY_MAX;
      min_mask   <= '0;
      wr_en      <= 1'b0;
    end else begin
      wr_en <= in_valid;
      if (in_valid) begin
        min_energy <= min_energy_next;
        min_mask   <= min_mask_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_data.energy         <= in_stage.sum;
    wr_data.best_candidate <= min_mask_next;
    wr_data.best_energy    <= min_energy_next;
  end

endmodule

[rtl/labs_ems_fifo.sv]
`timescale 1ns / 1ps
`include "labs_energy_min_search_defines.svh"
module labs_ems_fifo import labs_ems_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  logic    wr_en,
  input  result_t wr_data,
  input  logic    result_stall,
  output logic    full,
  output logic    result_valid,
  output result_t result
);

  result_t          mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   mem_count;
  logic [PTR_W:0]   occ;
  logic             load;
  logic             take;

  // Output register refills whenever the queue holds an entry and it is empty or being taken
  assign take = result_valid && !result_stall;
  assign load = (mem_count != '0) && (!result_valid || !result_stall);
  // Credits cover every request from acceptance until its result leaves
  assign full = (occ == (PTR_W+1)'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
    if (load) begin
      result <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      mem_count    <= '0;
      occ          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (load) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      mem_count <= mem_count + (PTR_W+1)'(wr_en) - (PTR_W+1)'(load);
      occ       <= occ + (PTR_W+1)'(accept) - (PTR_W+1)'(take);
      if (load) begin
        result_valid <= 1'b1;
      end else if (take) begin
        result_valid <= 1'b0;
      end
    end
  end

  `LABS_ASSERT_IMPL(a_no_overflow, clk, rst, wr_en, mem_count != (PTR_W+1)'(FIFO_DEPTH))
  `LABS_ASSERT_IMPL(a_credit_cover, clk, rst, 1'b1, occ >= mem_count + (PTR_W+1)'(result_valid))
  `LABS_ASSERT_IMPL(a_accept_room, clk, rst, accept, occ < (PTR_W+1)'(FIFO_DEPTH))
  `LABS_ASSERT_NEXT(a_drain, clk, rst, !result_valid && mem_count != '0, result_valid)

endmodule

[rtl/labs_energy_min_search.sv]
`timescale 1ns / 1ps
// Energy search for low-autocorrelation binary sequences.
// Item channel: item_valid / item_stall carry one candidate mask and a
// restart flag; a request is taken when item_valid is high and item_stall low.
// Result channel: result_valid / result_stall return, in order, the energy of
// each candidate plus the best mask and energy since the last restart.
// Config channel: cfg_valid / cfg_ready write seq_len; cfg_ready is always high.
// Write it only while no request is outstanding.
// Throughput: one request per cycle while item_stall is low. Each lag k has its
// own cell in a chain of 31 cells, two register stages each, so every cycle a
// new request can enter. Path: the input register loads at the accepting edge;
// then come 62 cell stages, the minimum tracker, the queue write and the output
// register load, which raises result_valid when the result side is free.
// Stall: results collect in a 128-entry queue; item_stall rises only when 128
// requests are accepted and not yet delivered, so inputs keep flowing while a
// finished result waits.
// Reset: synchronous; clears the pipeline, the queue, the running minimum
// (energy all ones, mask zero) and sets seq_len to 32.
module labs_energy_min_search import labs_ems_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  item_t            item,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data
);

  logic             cfg_write;
  logic [LEN_W-1:0] seq_len;
  logic [LEN_W-1:0] eff_len;
  logic             accept;

  logic             head_valid;
  stage_t           head_stage;

  logic             chain_valid [NUM_CELLS+1];
  stage_t           chain_stage [NUM_CELLS+1];

  logic             wr_en;
  result_t          wr_data;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign accept    = item_valid && !item_stall;

  // Length register
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len <= LEN_RESET;
    end else if (cfg_write) begin
      seq_len <= cfg_data;
    end
  end

  assign eff_len = (seq_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : seq_len;

  // Input register heads the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
    end else begin
      head_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    head_stage.candidate <= item.candidate;
    head_stage.restart   <= item.restart;
    head_stage.len       <= eff_len;
    head_stage.sum       <= '0;
  end

  assign chain_valid[0] = head_valid;
  assign chain_stage[0] = head_stage;

  // One cell per lag
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    labs_ems_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .lag       (LAG_W'(g + 1)),
      .in_valid  (chain_valid[g]),
      .in_stage  (chain_stage[g]),
      .out_valid (chain_valid[g+1]),
      .out_stage (chain_stage[g+1])
    );
  end

  labs_ems_min u_min (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chain_valid[NUM_CELLS]),
    .in_stage (chain_stage[NUM_CELLS]),
    .wr_en    (wr_en),
    .wr_data  (wr_data)
  );

  labs_ems_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .wr_en        (wr_en),
    .wr_data      (wr_data),
    .result_stall (result_stall),
    .full         (item_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
